// ===== sv/i2cm_pkg.sv =====
// shared types, codes and reset values of the i2c master transaction unit
package i2cm_pkg;

  // default width of the bus delay counter
  localparam int unsigned DELAY_WIDTH_DEF = 16;

  // command codes of an input beat
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_BEGIN  = 2'd1;
  localparam logic [1:0] CMD_SUPPLY = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_MODE  = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration reset values
  localparam logic [15:0] LOW_TICKS_RST  = 16'd10;
  localparam logic [15:0] HIGH_TICKS_RST = 16'd8;

  // bus sequencer phases
  localparam logic [3:0] PH_IDLE        = 4'd0;
  localparam logic [3:0] PH_WAIT_SCL    = 4'd1;
  localparam logic [3:0] PH_START_SETUP = 4'd2;
  localparam logic [3:0] PH_START_HOLD  = 4'd3;
  localparam logic [3:0] PH_BIT_LOW     = 4'd4;
  localparam logic [3:0] PH_BIT_WAIT    = 4'd5;
  localparam logic [3:0] PH_BIT_HIGH    = 4'd6;
  localparam logic [3:0] PH_GAP         = 4'd7;
  localparam logic [3:0] PH_WAIT_WRITE  = 4'd8;
  localparam logic [3:0] PH_STOP_WAIT   = 4'd9;
  localparam logic [3:0] PH_STOP_HOLD   = 4'd10;
  localparam logic [3:0] PH_STOP_SETUP  = 4'd11;

  // bit positions within a byte frame
  localparam logic [3:0] BIT_LAST_DATA = 4'd7;
  localparam logic [3:0] BIT_ACK       = 4'd8;
  localparam logic [3:0] BIT_ACK_DONE  = 4'd9;

  // input beat payload
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic [7:0] byte_count;
    logic       sda_in;
    logic       scl_in;
  } in_beat_t;

  // result beat payload
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       write_wanted;
    logic       busy_res;
    logic       done_res;
    logic       nacked;
  } out_beat_t;

  // timing configuration seen by the sequencer
  typedef struct packed {
    logic [15:0] low_ticks;
    logic [15:0] high_ticks;
    logic        fast_mode;
  } cfg_t;

  // hand-off between the input register and the result register
  typedef struct packed {
    logic s1_valid;
    logic take;
  } stage_ctl_t;

endpackage

// ===== sv/i2cm_in_if.sv =====
// input channel of the i2c master transaction unit
interface i2cm_in_if import i2cm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t beat;

  modport source (output valid, output beat, input ready);
  modport sink (input valid, input beat, output ready);
endinterface

// ===== sv/i2cm_out_if.sv =====
// result channel of the i2c master transaction unit
interface i2cm_out_if import i2cm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t beat;

  modport source (output valid, output beat, input ready);
  modport sink (input valid, input beat, output ready);
endinterface

// ===== sv/i2cm_in_stage.sv =====
// input register stage of the i2c master transaction unit
module i2cm_in_stage import i2cm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  i2cm_in_if.sink    in_ch,
  input  logic       take,
  output logic       s1_valid,
  output in_beat_t   s1_beat
);

  logic     s1_valid_r, s1_valid_nxt;
  in_beat_t s1_beat_r;
  logic     accept;

  // stage can take a beat when empty or when its beat moves on
  assign in_ch.ready = !s1_valid_r || take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_beat_r <= in_ch.beat;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_beat  = s1_beat_r;

endmodule

// ===== sv/i2cm_core.sv =====
// bus sequencer state and one-step next-state logic of the i2c master
module i2cm_core import i2cm_pkg::*; #(
  parameter int unsigned DELAY_WIDTH = DELAY_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       step_en,
  input  in_beat_t   beat,
  output out_beat_t  res
);

  logic [3:0]             phase_r, phase_nxt;
  logic [DELAY_WIDTH-1:0] delay_r, delay_nxt;
  logic [3:0]             bit_idx_r, bit_idx_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic [7:0]             left_r, left_nxt;
  logic                   addr_pend_r, addr_pend_nxt;
  logic                   wr_dir_r, wr_dir_nxt;

  logic [DELAY_WIDTH-1:0] lo_load, hi_load, setup_load;
  logic                   dly_last;
  logic                   sending;
  logic                   send_nxt;
  logic                   drive;
  logic                   rvalid, done, nack;
  logic                   scl_o, sda_o;

  // delay reload values cut or widened to the counter width
  assign lo_load    = DELAY_WIDTH'(cfg.low_ticks);
  assign hi_load    = DELAY_WIDTH'(cfg.high_ticks);
  assign setup_load = cfg.fast_mode ? hi_load : lo_load;
  assign dly_last   = (delay_r <= DELAY_WIDTH'(1));
  assign sending    = addr_pend_r || wr_dir_r;

  // next state for one beat
  always_comb begin
    phase_nxt     = phase_r;
    delay_nxt     = delay_r;
    bit_idx_nxt   = bit_idx_r;
    shift_nxt     = shift_r;
    left_nxt      = left_r;
    addr_pend_nxt = addr_pend_r;
    wr_dir_nxt    = wr_dir_r;
    rvalid        = 1'b0;
    done          = 1'b0;
    nack          = 1'b0;
    unique case (beat.command)
      CMD_BEGIN: begin
        if (phase_r == PH_IDLE) begin
          wr_dir_nxt    = !beat.data_byte[0];
          shift_nxt     = beat.data_byte;
          left_nxt      = (beat.byte_count == 8'd0) ? 8'd1 : beat.byte_count;
          addr_pend_nxt = 1'b1;
          bit_idx_nxt   = 4'd0;
          phase_nxt     = PH_WAIT_SCL;
        end
      end
      CMD_SUPPLY: begin
        if (phase_r == PH_WAIT_WRITE) begin
          shift_nxt   = beat.data_byte;
          bit_idx_nxt = 4'd0;
          phase_nxt   = PH_BIT_LOW;
          delay_nxt   = lo_load;
        end
      end
      CMD_TICK: begin
        // countdown of the running delay
        if (!dly_last && (phase_r == PH_START_SETUP || phase_r == PH_START_HOLD ||
            phase_r == PH_BIT_LOW || phase_r == PH_BIT_HIGH || phase_r == PH_GAP ||
            phase_r == PH_STOP_HOLD || phase_r == PH_STOP_SETUP)) begin
          delay_nxt = delay_r - DELAY_WIDTH'(1);
        end
        unique case (phase_r)
          PH_IDLE, PH_WAIT_WRITE: begin
          end
          PH_WAIT_SCL: begin
            if (beat.scl_in) begin
              delay_nxt = setup_load;
              phase_nxt = PH_START_SETUP;
            end
          end
          PH_START_SETUP: begin
            if (dly_last) begin
              delay_nxt = hi_load;
              phase_nxt = PH_START_HOLD;
            end
          end
          PH_START_HOLD: begin
            if (dly_last) begin
              bit_idx_nxt = 4'd0;
              delay_nxt   = lo_load;
              phase_nxt   = PH_BIT_LOW;
            end
          end
          PH_BIT_LOW: begin
            if (dly_last) begin
              phase_nxt = PH_BIT_WAIT;
            end
          end
          PH_BIT_WAIT: begin
            if (beat.scl_in) begin
              delay_nxt = hi_load;
              phase_nxt = PH_BIT_HIGH;
            end
          end
          PH_BIT_HIGH: begin
            if (dly_last) begin
              shift_nxt = {shift_r[6:0], beat.sda_in};
              if (bit_idx_r < BIT_LAST_DATA) begin
                bit_idx_nxt = bit_idx_r + 4'd1;
                delay_nxt   = lo_load;
                phase_nxt   = PH_BIT_LOW;
              end else begin
                bit_idx_nxt = (bit_idx_r < BIT_ACK) ? BIT_ACK : BIT_ACK_DONE;
                delay_nxt   = lo_load;
                phase_nxt   = PH_GAP;
              end
            end
          end
          PH_GAP: begin
            if (dly_last) begin
              if (bit_idx_r <= BIT_ACK) begin
                // data byte finished, go clock the acknowledge
                rvalid      = !sending;
                bit_idx_nxt = BIT_ACK;
                delay_nxt   = lo_load;
                phase_nxt   = PH_BIT_LOW;
              end else if (sending && shift_r[0]) begin
                // slave refused: abort without stop
                nack          = 1'b1;
                addr_pend_nxt = 1'b0;
                left_nxt      = 8'd0;
                shift_nxt     = 8'hFF;
                bit_idx_nxt   = 4'd0;
                phase_nxt     = PH_IDLE;
              end else begin
                addr_pend_nxt = 1'b0;
                shift_nxt     = 8'hFF;
                bit_idx_nxt   = 4'd0;
                if (left_r <= 8'd1) begin
                  left_nxt  = 8'd0;
                  phase_nxt = PH_STOP_WAIT;
                end else begin
                  left_nxt = left_r - 8'd1;
                  if (wr_dir_r) begin
                    phase_nxt = PH_WAIT_WRITE;
                  end else begin
                    delay_nxt = lo_load;
                    phase_nxt = PH_BIT_LOW;
                  end
                end
              end
            end
          end
          PH_STOP_WAIT: begin
            if (beat.scl_in) begin
              delay_nxt = hi_load;
              phase_nxt = PH_STOP_HOLD;
            end
          end
          PH_STOP_HOLD: begin
            if (dly_last) begin
              delay_nxt = lo_load;
              phase_nxt = PH_STOP_SETUP;
            end
          end
          PH_STOP_SETUP: begin
            if (dly_last) begin
              done      = 1'b1;
              phase_nxt = PH_IDLE;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // line drive from the updated state
  assign send_nxt = addr_pend_nxt || wr_dir_nxt;
  assign drive    = (bit_idx_nxt < BIT_ACK) ? shift_nxt[7] :
                    (send_nxt ? 1'b1 : (left_nxt <= 8'd1));

  always_comb begin
    scl_o = 1'b1;
    sda_o = 1'b1;
    unique case (phase_nxt)
      PH_START_HOLD: sda_o = 1'b0;
      PH_BIT_LOW: begin
        scl_o = 1'b0;
        sda_o = drive;
      end
      PH_BIT_WAIT, PH_BIT_HIGH: sda_o = drive;
      PH_GAP, PH_WAIT_WRITE: scl_o = 1'b0;
      PH_STOP_WAIT, PH_STOP_HOLD: sda_o = 1'b0;
      default: begin
      end
    endcase
  end

  always_comb begin
    res.scl_out      = scl_o;
    res.sda_out      = sda_o;
    res.read_byte    = rvalid ? shift_r : 8'd0;
    res.read_valid   = rvalid;
    res.write_wanted = (phase_nxt == PH_WAIT_WRITE);
    res.busy_res     = (phase_nxt != PH_IDLE) && (phase_nxt <= PH_STOP_SETUP);
    res.done_res     = done;
    res.nacked       = nack;
  end

  // sequencer state, advanced once per beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      delay_r     <= '0;
      bit_idx_r   <= 4'd0;
      shift_r     <= 8'hFF;
      left_r      <= 8'd0;
      addr_pend_r <= 1'b0;
      wr_dir_r    <= 1'b0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      delay_r     <= delay_nxt;
      bit_idx_r   <= bit_idx_nxt;
      shift_r     <= shift_nxt;
      left_r      <= left_nxt;
      addr_pend_r <= addr_pend_nxt;
      wr_dir_r    <= wr_dir_nxt;
    end
  end

endmodule

// ===== sv/i2cm_out_stage.sv =====
// result register stage of the i2c master transaction unit
module i2cm_out_stage import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  out_beat_t   res,
  input  logic        s1_valid,
  output stage_ctl_t  ctl,
  i2cm_out_if.source  out_ch
);

  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_beat_r;
  logic      take;
  logic      load;

  // the register frees up when empty or when its beat leaves
  assign take = !out_valid_r || out_ch.ready;
  assign load = s1_valid && take;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      out_beat_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.beat  = out_beat_r;
  assign ctl.s1_valid = s1_valid;
  assign ctl.take     = take;

endmodule

// ===== sv/i2c_master_transaction_unit.sv =====
// top level of the i2c master transaction unit
//
//   channel  | dir | handshake            | payload
//   in_ch    | in  | valid/ready          | command, data_byte, byte_count, sda_in, scl_in
//   out_ch   | out | valid/ready          | scl_out, sda_out, read_byte, read_valid,
//            |     |                      | write_wanted, busy_res, done_res, nacked
//   cfg_*    | in  | cfg_we, no back-pres | cfg_index, cfg_data
//
// one beat per clock while out_ch does not stall; a beat enters the input register at
// acceptance, its result enters the result register when free (one sequencer step)
// reset is synchronous on rst_n: sequencer idle, timing registers at 10 and 8, fast_mode 0
// a stalled out_ch holds its beat; the input register still takes one more beat,
// then in_ch.ready drops until the result register frees
module i2c_master_transaction_unit import i2cm_pkg::*; #(
  parameter int unsigned DELAY_WIDTH = DELAY_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  i2cm_in_if.sink               in_ch,
  i2cm_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg_r, cfg_nxt;
  stage_ctl_t ctl;
  logic       s1_valid;
  in_beat_t   s1_beat;
  out_beat_t  res;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOW_TICKS:  cfg_nxt.low_ticks  = cfg_data;
        CFG_HIGH_TICKS: cfg_nxt.high_ticks = cfg_data;
        CFG_FAST_MODE:  cfg_nxt.fast_mode  = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_ticks  <= LOW_TICKS_RST;
      cfg_r.high_ticks <= HIGH_TICKS_RST;
      cfg_r.fast_mode  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  i2cm_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .take     (ctl.take),
    .s1_valid (s1_valid),
    .s1_beat  (s1_beat)
  );

  i2cm_core #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .step_en (ctl.s1_valid && ctl.take),
    .beat    (s1_beat),
    .res     (res)
  );

  i2cm_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .s1_valid (s1_valid),
    .ctl      (ctl),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  // input side only stalls when both registers hold beats and the output is blocked
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid && out_ch.valid && !out_ch.ready))
    else $error("input stalled without a full pipeline");

  // a finished stop leaves the sequencer idle
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.beat.done_res) |-> !out_ch.beat.busy_res)
    else $error("done reported while still busy");

  // an abort releases both bus lines at once
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.beat.nacked) |->
      (out_ch.beat.scl_out && out_ch.beat.sda_out && !out_ch.beat.busy_res))
    else $error("nack abort left a line driven");

  // a received byte is followed at once by the acknowledge clock low period
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.beat.read_valid) |->
      (!out_ch.beat.scl_out && out_ch.beat.busy_res && !out_ch.beat.write_wanted))
    else $error("read byte delivered outside the acknowledge slot");
`endif

endmodule
